FILE: rtl/rclog_pkg.sv
//------------------------------------------------------------------------------
// rclog_pkg
// Shared types, constants and the Gaussian weight table for the grid updater.
//------------------------------------------------------------------------------
`default_nettype none
package rclog_pkg;

    localparam int LO_W  = 9;
    localparam int CNT_W = 13;
    localparam int NONZERO_WEIGHTS = 100;

    localparam logic [2:0] REG_HIT_STEP  = 3'd0;
    localparam logic [2:0] REG_FREE_STEP = 3'd1;
    localparam logic [2:0] REG_FLOOR     = 3'd2;
    localparam logic [2:0] REG_CEILING   = 3'd3;
    localparam logic [2:0] REG_OCC_TH    = 3'd4;
    localparam logic [2:0] REG_FREE_TH   = 3'd5;
    localparam logic [2:0] REG_WSCALE    = 3'd6;

    localparam logic       OP_RAY  = 1'b0;
    localparam logic       OP_READ = 1'b1;

    localparam logic [1:0] CLS_FREE    = 2'd0;
    localparam logic [1:0] CLS_OCC     = 2'd1;
    localparam logic [1:0] CLS_UNKNOWN = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture item, set up line
        logic clr_step;  // clear pass: write zero at clear address
        logic rd_cur;    // issue read of current cell
        logic rmw_cur;   // compute/write free update of current cell
        logic advance;   // take one Bresenham step
        logic rd_end;    // issue read of end cell
        logic wr_hit;    // write hit update of end cell
        logic rd_final;  // issue read of end cell for result
        logic capture;   // latch result fields
    } rclog_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic at_end;    // current cell equals end cell
        logic cur_in;    // current cell in grid
        logic end_in;    // end cell in grid
        logic is_read;   // captured operation is a read
        logic clr_done;  // last clear address reached
    } rclog_sts_t;

    // round(256*exp(-i/16)), zero from NONZERO_WEIGHTS on
    function automatic logic [8:0] gauss_q8(input logic [6:0] i);
        logic [8:0] w;
        case (i)
            7'd0: w = 9'd256;  7'd1: w = 9'd240;  7'd2: w = 9'd226;  7'd3: w = 9'd212;
            7'd4: w = 9'd199;  7'd5: w = 9'd187;  7'd6: w = 9'd176;  7'd7: w = 9'd165;
            7'd8: w = 9'd155;  7'd9: w = 9'd146;  7'd10: w = 9'd137; 7'd11: w = 9'd129;
            7'd12: w = 9'd121; 7'd13: w = 9'd114; 7'd14: w = 9'd107; 7'd15: w = 9'd100;
            7'd16: w = 9'd94;  7'd17: w = 9'd88;  7'd18: w = 9'd83;  7'd19: w = 9'd78;
            7'd20: w = 9'd73;  7'd21: w = 9'd69;  7'd22: w = 9'd65;  7'd23: w = 9'd61;
            7'd24: w = 9'd57;  7'd25: w = 9'd54;  7'd26: w = 9'd50;  7'd27: w = 9'd47;
            7'd28: w = 9'd44;  7'd29: w = 9'd42;  7'd30: w = 9'd39;  7'd31: w = 9'd37;
            7'd32: w = 9'd35;  7'd33: w = 9'd33;  7'd34: w = 9'd31;  7'd35: w = 9'd29;
            7'd36: w = 9'd27;  7'd37: w = 9'd25;  7'd38: w = 9'd24;  7'd39: w = 9'd22;
            7'd40: w = 9'd21;  7'd41: w = 9'd20;  7'd42: w = 9'd19;  7'd43: w = 9'd17;
            7'd44: w = 9'd16;  7'd45: w = 9'd15;  7'd46: w = 9'd14;  7'd47: w = 9'd14;
            7'd48: w = 9'd13;  7'd49: w = 9'd12;  7'd50: w = 9'd11;  7'd51: w = 9'd11;
            7'd52: w = 9'd10;  7'd53: w = 9'd9;   7'd54: w = 9'd9;   7'd55: w = 9'd8;
            7'd56: w = 9'd8;   7'd57: w = 9'd7;   7'd58: w = 9'd7;   7'd59: w = 9'd6;
            7'd60: w = 9'd6;   7'd61: w = 9'd6;   7'd62: w = 9'd5;   7'd63: w = 9'd5;
            7'd64: w = 9'd5;   7'd65: w = 9'd4;   7'd66: w = 9'd4;   7'd67: w = 9'd4;
            7'd68: w = 9'd4;   7'd69: w = 9'd3;   7'd70: w = 9'd3;   7'd71: w = 9'd3;
            7'd72: w = 9'd3;   7'd73: w = 9'd3;   7'd74: w = 9'd3;   7'd75: w = 9'd2;
            7'd76: w = 9'd2;   7'd77: w = 9'd2;   7'd78: w = 9'd2;   7'd79: w = 9'd2;
            7'd80: w = 9'd2;   7'd81: w = 9'd2;   7'd82: w = 9'd2;
            default: w = (i < 7'(NONZERO_WEIGHTS)) ? 9'd1 : 9'd0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ray_cast_log_odds_grid_update.sv
//------------------------------------------------------------------------------
// ray_cast_log_odds_grid_update
// Bresenham ray walk with weighted log-odds free/hit updates on a grid store.
//------------------------------------------------------------------------------
// s_ channel takes one item: tuser = operation (0 ray, 1 read), tdata holds
// robot_x_fix, robot_y_fix, end_x, end_y. m_ channel returns one item per input.
// For each in-grid line cell a ray does a step check, a read, a weight
// multiply and a write back on the single store port; an off-grid cell only
// gets the step check. Then come the end check, the hit (read, wait, write;
// skipped if the end is off-grid) and the readout (read, wait, capture).
// A read does the check and the readout. The next item is accepted in the
// cycle after the result is taken, never while an item is in flight.
// The store port sets the rate. Reset (aresetn low, synchronous) loads
// register defaults and starts a pass that zeroes all GRID_SIDE*GRID_SIDE cells,
// during which s_tready stays low; configuration writes are taken at any
// time. The result sits in an output register; while the receiver stalls the
// next item is not taken until the held item goes.
//------------------------------------------------------------------------------
`default_nettype none
module ray_cast_log_odds_grid_update #(
    parameter int GRID_SIDE = 256,
    parameter int WEIGHT_TABLE_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] robot_x_fix, [31:16] robot_y_fix, [43:32] end_x, [55:44] end_y
    input  wire logic [55:0] s_tdata,
    // [0] operation
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [8:0] cell_log_odds, [10:9] cell_class, [11] end_in_grid,
    // [24:12] free_cells_updated
    output logic      [31:0] m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    import rclog_pkg::*;

    rclog_cmd_t cmd;
    rclog_sts_t sts;
    logic [24:0] res;

    rclog_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .cmd(cmd), .sts(sts)
    );

    rclog_dp #(.GRID_SIDE(GRID_SIDE), .WEIGHT_TABLE_DEPTH(WEIGHT_TABLE_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .m_tdata(res), .cmd(cmd), .sts(sts)
    );

    assign m_tdata = {7'd0, res};
endmodule
`default_nettype wire

FILE: rtl/rclog_ram.sv
//------------------------------------------------------------------------------
// rclog_ram
// Generic single-port RAM with registered read.
//------------------------------------------------------------------------------
`default_nettype none
module rclog_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: rtl/rclog_ctrl.sv
//------------------------------------------------------------------------------
// rclog_ctrl
// Sequencer: clear pass, per-cell read-modify-write walk, hit and readout.
//------------------------------------------------------------------------------
`default_nettype none
module rclog_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output rclog_pkg::rclog_cmd_t   cmd,
    input  wire rclog_pkg::rclog_sts_t sts
);
    import rclog_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CHECK, ST_RD, ST_MUL, ST_WR,
        ST_HRD, ST_HWAIT, ST_HWR, ST_FRD, ST_FWAIT, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   mval_reg, mval_next;

    // ST_RD and ST_MUL both address the current cell, so its data is still
    // there in ST_WR; the weight product is registered in ST_MUL
    always_comb begin
        state_next = state_reg;
        mval_next  = mval_reg;
        cmd        = '0;
        if (m_tvalid && m_tready) begin
            mval_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid && !mval_reg) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.is_read) state_next = ST_FRD;
                else if (sts.at_end) state_next = ST_HRD;
                else if (sts.cur_in) state_next = ST_RD;
                else begin
                    cmd.advance = 1'b1;
                end
            end
            ST_RD: begin
                cmd.rd_cur = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.rd_cur = 1'b1;
                state_next = ST_WR;
            end
            ST_WR: begin
                cmd.rmw_cur = 1'b1;
                cmd.advance = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_HRD: begin
                if (sts.end_in) begin
                    cmd.rd_end = 1'b1;
                    state_next = ST_HWAIT;
                end else state_next = ST_FRD;
            end
            ST_HWAIT: state_next = ST_HWR;
            ST_HWR: begin
                cmd.wr_hit = 1'b1;
                state_next = ST_FRD;
            end
            ST_FRD: begin
                cmd.rd_final = 1'b1;
                state_next   = ST_FWAIT;
            end
            ST_FWAIT: state_next = ST_OUT;
            ST_OUT: begin
                cmd.capture = 1'b1;
                mval_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !mval_reg;
    assign m_tvalid = mval_reg;
endmodule
`default_nettype wire

FILE: rtl/rclog_dp.sv
//------------------------------------------------------------------------------
// rclog_dp
// Datapath: line stepper, distance weight, clamps, store and result register.
//------------------------------------------------------------------------------
`default_nettype none
module rclog_dp #(
    parameter int GRID_SIDE = 256,
    parameter int WEIGHT_TABLE_DEPTH = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [55:0]        s_tdata,
    input  wire logic               s_tuser,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [23:0]        cfg_data,
    output logic      [24:0]        m_tdata,
    input  wire rclog_pkg::rclog_cmd_t cmd,
    output rclog_pkg::rclog_sts_t   sts
);
    import rclog_pkg::*;

    localparam int GW    = $clog2(GRID_SIDE);
    localparam int AW    = 2 * GW;
    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int TIW   = $clog2(WEIGHT_TABLE_DEPTH);

    // configuration
    logic        [7:0]  hit_reg, ceil_reg;
    logic signed [8:0]  fstep_reg, floor_reg, occ_reg, fth_reg;
    logic        [23:0] wsc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg   <= 8'd29;
            fstep_reg <= -9'sd13;
            floor_reg <= -9'sd64;
            ceil_reg  <= 8'd160;
            occ_reg   <= 9'sd16;
            fth_reg   <= -9'sd16;
            wsc_reg   <= 24'd1311;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_HIT_STEP:  hit_reg   <= cfg_data[7:0];
                REG_FREE_STEP: fstep_reg <= cfg_data[8:0];
                REG_FLOOR:     floor_reg <= cfg_data[8:0];
                REG_CEILING:   ceil_reg  <= cfg_data[7:0];
                REG_OCC_TH:    occ_reg   <= cfg_data[8:0];
                REG_FREE_TH:   fth_reg   <= cfg_data[8:0];
                REG_WSCALE:    wsc_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // item fields
    logic               op_reg;
    logic signed [15:0] rx_reg, ry_reg;
    logic signed [11:0] ex_reg, ey_reg;
    logic signed [12:0] x_reg, y_reg, dx_reg, dy_reg;
    logic signed [14:0] err_reg;
    logic               sx_reg, sy_reg;   // 1 = positive step
    logic [CNT_W-1:0]   cnt_reg;
    logic [AW-1:0]      clr_reg;

    logic signed [12:0] exw, eyw, dxa, dya;
    logic signed [14:0] e2, err_n;
    assign exw = 13'(ex_reg);
    assign eyw = 13'(ey_reg);

    logic signed [12:0] lx0, ly0, lex, ley;
    assign lx0 = 13'($signed(s_tdata[15:0]) >>> 4);
    assign ly0 = 13'($signed(s_tdata[31:16]) >>> 4);
    assign lex = 13'($signed(s_tdata[43:32]));
    assign ley = 13'($signed(s_tdata[55:44]));
    assign dxa = (lex > lx0) ? lex - lx0 : lx0 - lex;
    assign dya = (ley > ly0) ? ley - ly0 : ly0 - ley;

    function automatic logic in_grid(input logic signed [12:0] a,
                                     input logic signed [12:0] b);
        return a >= 0 && a < 13'(GRID_SIDE) && b >= 0 && b < 13'(GRID_SIDE);
    endfunction

    assign e2 = err_reg <<< 1;

    always_comb begin
        err_n = err_reg;
        if (e2 > -15'(dy_reg)) err_n = err_n - 15'(dy_reg);
        if (e2 < 15'(dx_reg))  err_n = err_n + 15'(dx_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + 1'b1;
        end
        if (cmd.load) begin
            op_reg  <= s_tuser;
            rx_reg  <= s_tdata[15:0];
            ry_reg  <= s_tdata[31:16];
            ex_reg  <= s_tdata[43:32];
            ey_reg  <= s_tdata[55:44];
            x_reg   <= lx0;
            y_reg   <= ly0;
            dx_reg  <= dxa;
            dy_reg  <= dya;
            sx_reg  <= lx0 < lex;
            sy_reg  <= ly0 < ley;
            err_reg <= 15'(dxa) - 15'(dya);
            cnt_reg <= '0;
        end else if (cmd.advance) begin
            err_reg <= err_n;
            if (e2 > -15'(dy_reg)) x_reg <= sx_reg ? x_reg + 1'b1 : x_reg - 1'b1;
            if (e2 < 15'(dx_reg))  y_reg <= sy_reg ? y_reg + 1'b1 : y_reg - 1'b1;
        end
        if (cmd.rmw_cur) cnt_reg <= cnt_reg + 1'b1;
    end

    assign sts.at_end   = (x_reg == exw) && (y_reg == eyw);
    assign sts.cur_in   = in_grid(x_reg, y_reg);
    assign sts.end_in   = in_grid(exw, eyw);
    assign sts.is_read  = op_reg == OP_READ;
    assign sts.clr_done = clr_reg == AW'(DEPTH - 1);

    // weight: distance terms registered during read cycle
    logic signed [17:0] ddx, ddy;
    logic        [35:0] d2_sum;
    logic        [59:0] prod;
    logic [TIW-1:0]     idx;
    logic [8:0]         wgt;
    assign ddx = 18'(x_reg) * 18'sd16 + 18'sd8 - 18'(rx_reg);
    assign ddy = 18'(y_reg) * 18'sd16 + 18'sd8 - 18'(ry_reg);

    logic [35:0] sq_x_reg, sq_y_reg;
    always_ff @(posedge aclk) begin
        if (cmd.rd_cur) begin
            sq_x_reg <= 36'(ddx * ddx);
            sq_y_reg <= 36'(ddy * ddy);
        end
    end
    assign d2_sum = sq_x_reg + sq_y_reg;
    // product registered in the MUL cycle
    logic [59:0] prod_reg;
    assign prod = 60'(d2_sum) * 60'(wsc_reg);
    always_ff @(posedge aclk) prod_reg <= prod;

    always_comb begin
        if (prod_reg[59:24] > 36'(WEIGHT_TABLE_DEPTH - 1))
            idx = TIW'(WEIGHT_TABLE_DEPTH - 1);
        else
            idx = prod_reg[24 +: TIW];
        wgt = (int'(idx) < NONZERO_WEIGHTS) ? gauss_q8(7'(idx)) : 9'd0;
    end

    // store
    logic              we;
    logic [AW-1:0]     addr, cur_a, end_a;
    logic [LO_W-1:0]   wdata, rdata;
    assign cur_a = {y_reg[GW-1:0], x_reg[GW-1:0]};
    assign end_a = {ey_reg[GW-1:0], ex_reg[GW-1:0]};

    logic signed [17:0] p, mag, r;
    logic signed [12:0] v_free, v_hit;
    logic signed [8:0]  vf_s, vh_s;
    assign p   = 18'(fstep_reg) * $signed({9'd0, wgt});
    assign mag = (p < 0) ? -p : p;
    assign r   = (mag + 18'sd128) >>> 8;
    assign v_free = 13'($signed(rdata)) + ((p < 0) ? -13'(r) : 13'(r));

    function automatic logic signed [8:0] sat9(input logic signed [12:0] v);
        if (v < -13'sd256) return -9'sd256;
        if (v > 13'sd255)  return 9'sd255;
        return 9'(v);
    endfunction

    always_comb begin
        if (v_free < 13'(floor_reg)) vf_s = sat9(13'(floor_reg));
        else vf_s = sat9(v_free);
        v_hit = 13'($signed(rdata)) + 13'($signed({1'b0, hit_reg}));
        if (v_hit > 13'($signed({1'b0, ceil_reg}))) vh_s = sat9(13'($signed({1'b0, ceil_reg})));
        else vh_s = sat9(v_hit);
    end

    always_comb begin
        we    = 1'b0;
        wdata = '0;
        addr  = end_a;
        if (cmd.clr_step) begin
            we = 1'b1; addr = clr_reg;
        end else if (cmd.rd_cur || cmd.rmw_cur) begin
            addr = cur_a; we = cmd.rmw_cur; wdata = vf_s;
        end else if (cmd.wr_hit) begin
            we = 1'b1; wdata = vh_s;
        end
    end

    rclog_ram #(.WIDTH(LO_W), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // result
    logic signed [8:0] lo;
    logic [1:0]        cls;
    always_comb begin
        lo  = sts.end_in ? $signed(rdata) : 9'sd0;
        cls = CLS_UNKNOWN;
        if (sts.end_in) begin
            if (lo > occ_reg) cls = CLS_OCC;
            else if (lo < fth_reg) cls = CLS_FREE;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            m_tdata <= {cnt_reg, sts.end_in, cls, lo};
        end
    end
endmodule
`default_nettype wire
